// ===== rtl/core/cosnh_pkg.sv =====
// Shared types and protocol constants of the CANopen slave.
package cosnh_pkg;

   // item kinds
   localparam logic [1:0] OP_FRAME = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // configuration register indexes
   localparam logic CSR_NODE_ID     = 1'b0;
   localparam logic CSR_DEVICE_TYPE = 1'b1;

   // NMT state codes
   localparam logic [6:0] NMT_INIT    = 7'd0;
   localparam logic [6:0] NMT_HALTED  = 7'd4;
   localparam logic [6:0] NMT_OPER    = 7'd5;
   localparam logic [6:0] NMT_PREOP   = 7'd127;

   // NMT commands
   localparam logic [7:0] NMT_CMD_OPERATE   = 8'h01;
   localparam logic [7:0] NMT_CMD_HALT      = 8'h02;
   localparam logic [7:0] NMT_CMD_PREOP     = 8'h80;
   localparam logic [7:0] NMT_CMD_RST_NODE  = 8'h81;
   localparam logic [7:0] NMT_CMD_RST_COMM  = 8'h82;

   // COB-ID bases
   localparam logic [10:0] COB_NMT         = 11'h000;
   localparam logic [10:0] COB_SDO_REPLY   = 11'h580;
   localparam logic [10:0] COB_SDO_REQUEST = 11'h600;
   localparam logic [10:0] COB_HEARTBEAT   = 11'h700;

   // SDO client command specifiers
   localparam logic [2:0] CCS_DOWNLOAD = 3'd1;
   localparam logic [2:0] CCS_UPLOAD   = 3'd2;

   // SDO server commands
   localparam logic [7:0] SCS_ACK      = 8'h60;
   localparam logic [7:0] SCS_ABORT    = 8'h80;
   localparam logic [7:0] SCS_UPLOAD_4 = 8'h43;
   localparam logic [7:0] SCS_UPLOAD_2 = 8'h4B;
   localparam logic [7:0] SCS_UPLOAD_1 = 8'h4F;

   localparam logic [31:0] ABORT_NO_SUPPORT = 32'h0601_0000;
   localparam logic [31:0] ABORT_NO_OBJECT  = 32'h0602_0000;

   // object dictionary indexes
   localparam logic [15:0] OBJ_DEVICE_TYPE = 16'h1000;
   localparam logic [15:0] OBJ_ERROR_REG   = 16'h1001;
   localparam logic [15:0] OBJ_HEARTBEAT   = 16'h1017;
   localparam logic [15:0] OBJ_CONTROL     = 16'h6040;
   localparam logic [15:0] OBJ_MODE        = 16'h6060;
   localparam logic [15:0] OBJ_TARGET_VEL  = 16'h60FF;
   localparam logic [15:0] OBJ_AMPLITUDE   = 16'h2001;

   localparam logic [7:0] MODE_POSITION = 8'd1;
   localparam logic [7:0] MODE_VELOCITY = 8'd3;
   localparam logic [7:0] AMPLITUDE_MAX = 8'd100;

   localparam logic [15:0] HEARTBEAT_DEFAULT = 16'd1000;
   localparam logic [6:0]  NODE_ID_DEFAULT   = 7'd16;

   typedef struct packed {
      logic [6:0]  nmt_code;
      logic [15:0] heartbeat_ms;
      logic [31:0] elapsed_ms;
      logic        mode_velocity;
      logic [31:0] target_speed;
      logic [6:0]  amplitude;
   } node_type;

   typedef struct packed {
      logic        tx_valid;
      logic [10:0] tx_id;
      logic [3:0]  tx_length;
      logic [63:0] tx_data;
      logic [6:0]  node_state;
      logic        speed_mode;
      logic [31:0] target_velocity;
      logic [6:0]  amplitude_level;
      logic [15:0] heartbeat_period;
   } result_type;

   function automatic logic [63:0] sdo_frame(input logic [7:0]  cmd,
                                             input logic [15:0] idx,
                                             input logic [7:0]  sub,
                                             input logic [31:0] payload);
      return {payload, sub, idx, cmd};
   endfunction

endpackage

// ===== rtl/core/cosnh_proc.sv =====
// Frame decode, NMT and SDO handling, heartbeat timing and reply formatting.
module cosnh_proc (
   input  logic [1:0]           opcode,
   input  logic [10:0]          can_id,
   input  logic [3:0]           frame_length,
   input  logic [63:0]          frame_data,
   input  logic [6:0]           node_id,
   input  logic [31:0]          device_type,
   input  cosnh_pkg::node_type  cur,
   output cosnh_pkg::node_type  nxt,
   output cosnh_pkg::result_type result
);
   import cosnh_pkg::*;

   logic [7:0]  b0;
   logic [2:0]  ccs;
   logic [15:0] idx;
   logic [7:0]  sub;
   logic [7:0]  b4;
   logic [31:0] w;
   logic [7:0]  nid;
   logic [10:0] sdo_tx_id;
   logic [10:0] hb_id;

   assign b0        = frame_data[7:0];
   assign ccs       = b0[7:5];
   assign idx       = frame_data[23:8];
   assign sub       = frame_data[31:24];
   assign b4        = frame_data[39:32];
   assign w         = frame_data[63:32];
   assign nid       = frame_data[15:8];
   assign sdo_tx_id = COB_SDO_REPLY + {4'b0, node_id};
   assign hb_id     = COB_HEARTBEAT + {4'b0, node_id};

   always_comb begin
      logic        tx_on;
      logic [10:0] tx_id;
      logic [3:0]  tx_len;
      logic [63:0] tx_data;
      logic [31:0] elapsed_inc;

      nxt     = cur;
      tx_on   = 1'b0;
      tx_id   = '0;
      tx_len  = '0;
      tx_data = '0;
      elapsed_inc = (cur.elapsed_ms == '1) ? cur.elapsed_ms : cur.elapsed_ms + 32'd1;

      case (opcode)
         OP_FRAME: begin
            if (can_id == COB_NMT) begin
               if (frame_length >= 4'd2 && (nid == 8'd0 || nid == {1'b0, node_id})) begin
                  case (b0)
                     NMT_CMD_OPERATE: nxt.nmt_code = NMT_OPER;
                     NMT_CMD_HALT:    nxt.nmt_code = NMT_HALTED;
                     NMT_CMD_PREOP:   nxt.nmt_code = NMT_PREOP;
                     NMT_CMD_RST_NODE, NMT_CMD_RST_COMM: begin
                        nxt.nmt_code = NMT_PREOP;
                        tx_on  = 1'b1;
                        tx_id  = hb_id;
                        tx_len = 4'd1;
                     end
                     default: ;
                  endcase
               end
            end else if (can_id == COB_SDO_REQUEST + {4'b0, node_id}) begin
               case (ccs)
                  CCS_DOWNLOAD: begin
                     if (!b0[1]) begin
                        tx_on   = 1'b1;
                        tx_data = sdo_frame(SCS_ABORT, idx, sub, ABORT_NO_SUPPORT);
                     end else begin
                        case (idx)
                           OBJ_HEARTBEAT: begin
                              tx_on = 1'b1;
                              if (sub == 8'd0) begin
                                 nxt.heartbeat_ms = w[15:0];
                                 tx_data = sdo_frame(SCS_ACK, idx, sub, '0);
                              end else begin
                                 tx_data = sdo_frame(SCS_ABORT, idx, sub, ABORT_NO_OBJECT);
                              end
                           end
                           OBJ_CONTROL: begin
                              tx_on   = 1'b1;
                              tx_data = sdo_frame(SCS_ACK, idx, sub, '0);
                           end
                           OBJ_MODE: begin
                              if (sub == 8'd0) begin
                                 if (b4 == MODE_POSITION) nxt.mode_velocity = 1'b0;
                                 else if (b4 == MODE_VELOCITY) nxt.mode_velocity = 1'b1;
                                 tx_on   = 1'b1;
                                 tx_data = sdo_frame(SCS_ACK, idx, sub, '0);
                              end
                           end
                           OBJ_TARGET_VEL: begin
                              if (sub == 8'd0) begin
                                 nxt.target_speed = w;
                                 tx_on   = 1'b1;
                                 tx_data = sdo_frame(SCS_ACK, idx, sub, '0);
                              end
                           end
                           OBJ_AMPLITUDE: begin
                              if (sub == 8'd0) begin
                                 if (b4 <= AMPLITUDE_MAX) nxt.amplitude = b4[6:0];
                                 tx_on   = 1'b1;
                                 tx_data = sdo_frame(SCS_ACK, idx, sub, '0);
                              end
                           end
                           default: begin
                              tx_on   = 1'b1;
                              tx_data = sdo_frame(SCS_ABORT, idx, sub, ABORT_NO_OBJECT);
                           end
                        endcase
                     end
                  end
                  CCS_UPLOAD: begin
                     tx_on = 1'b1;
                     case (idx)
                        OBJ_DEVICE_TYPE:
                           tx_data = sdo_frame(SCS_UPLOAD_4, idx, sub, device_type);
                        OBJ_ERROR_REG:
                           tx_data = sdo_frame(SCS_UPLOAD_1, idx, sub, '0);
                        OBJ_HEARTBEAT:
                           tx_data = sdo_frame(SCS_UPLOAD_2, idx, sub,
                                               {16'b0, cur.heartbeat_ms});
                        OBJ_MODE:
                           tx_data = sdo_frame(SCS_UPLOAD_1, idx, sub,
                                               {24'b0, cur.mode_velocity ? MODE_VELOCITY
                                                                         : MODE_POSITION});
                        OBJ_TARGET_VEL:
                           tx_data = sdo_frame(SCS_UPLOAD_4, idx, sub, cur.target_speed);
                        OBJ_AMPLITUDE:
                           tx_data = sdo_frame(SCS_UPLOAD_1, idx, sub,
                                               {25'b0, cur.amplitude});
                        default:
                           tx_data = sdo_frame(SCS_ABORT, idx, sub, ABORT_NO_OBJECT);
                     endcase
                  end
                  default: ;
               endcase
               if (tx_on) begin
                  tx_id  = sdo_tx_id;
                  tx_len = 4'd8;
               end
            end
         end
         OP_TICK: begin
            nxt.elapsed_ms = elapsed_inc;
            if (cur.heartbeat_ms != 16'd0 && elapsed_inc >= {16'b0, cur.heartbeat_ms}) begin
               nxt.elapsed_ms = '0;
               tx_on   = 1'b1;
               tx_id   = hb_id;
               tx_len  = 4'd1;
               tx_data = {57'b0, cur.nmt_code};
            end
         end
         OP_START: begin
            nxt.nmt_code = NMT_PREOP;
            tx_on  = 1'b1;
            tx_id  = hb_id;
            tx_len = 4'd1;
         end
         default: ;
      endcase

      result.tx_valid         = tx_on;
      result.tx_id            = tx_id;
      result.tx_length        = tx_len;
      result.tx_data          = tx_data;
      result.node_state       = nxt.nmt_code;
      result.speed_mode       = nxt.mode_velocity;
      result.target_velocity  = nxt.target_speed;
      result.amplitude_level  = nxt.amplitude;
      result.heartbeat_period = nxt.heartbeat_ms;
   end

endmodule

// ===== rtl/core/cosnh_outbuf.sv =====
// Result register with a skid stage so the input side can take one more item on a stall.
module cosnh_outbuf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cosnh_pkg::result_type push_data,
   output logic                  space,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cosnh_pkg::result_type out_data
);
   import cosnh_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop       = main_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // input is held off; drain the skid beat into the main slot
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== rtl/core/canopen_slave_nmt_sdo_heartbeat.sv =====
// Top level of the CANopen slave: node state, configuration and result channel.
//
// Each accepted req_ beat is one item: a received CAN frame, a 1 ms tick or a
// start command. Every item yields exactly one rsp_ beat carrying the frame to
// send (rsp_tx_valid high) or none, plus a snapshot of the node state after it.
// Decode, dictionary update and reply formatting happen in the cycle the item
// is accepted; the result is registered in the output register, or in the skid
// stage while that is held; one item can be taken every cycle while the receiver does not stall.
// The output register is backed by a one-entry skid stage: when the receiver
// stalls, one more item is still taken, then req_ready drops until the skid
// beat moves on. csr_ beats write node_id (index 0) or device_type (index 1)
// and are always taken; write them only while no item is in flight.
// Reset is synchronous: the node starts initializing (state 0), heartbeat
// period 1000 ms, node_id 16, all dictionary values zero and both result
// stages empty.
module canopen_slave_nmt_sdo_heartbeat (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [10:0] req_can_id,
   input  logic [3:0]  req_frame_length,
   input  logic [63:0] req_frame_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tx_valid,
   output logic [10:0] rsp_tx_id,
   output logic [3:0]  rsp_tx_length,
   output logic [63:0] rsp_tx_data,
   output logic [6:0]  rsp_node_state,
   output logic        rsp_speed_mode,
   output logic signed [31:0] rsp_target_velocity,
   output logic [6:0]  rsp_amplitude_level,
   output logic [15:0] rsp_heartbeat_period,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);
   import cosnh_pkg::*;

   logic [6:0]  node_id_ff;
   logic [31:0] device_type_ff;
   node_type    node_ff, node_in;
   result_type  result;
   result_type  rsp_data;
   logic        accept;
   logic        space;

   assign csr_ready = 1'b1;
   assign req_ready = space;
   assign accept    = req_valid && space;

   cosnh_proc u_proc (
      .opcode       (req_opcode),
      .can_id       (req_can_id),
      .frame_length (req_frame_length),
      .frame_data   (req_frame_data),
      .node_id      (node_id_ff),
      .device_type  (device_type_ff),
      .cur          (node_ff),
      .nxt          (node_in),
      .result       (result)
   );

   cosnh_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff             <= NODE_ID_DEFAULT;
         device_type_ff         <= '0;
         node_ff.nmt_code       <= NMT_INIT;
         node_ff.heartbeat_ms   <= HEARTBEAT_DEFAULT;
         node_ff.elapsed_ms     <= '0;
         node_ff.mode_velocity  <= 1'b0;
         node_ff.target_speed   <= '0;
         node_ff.amplitude      <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_NODE_ID:     node_id_ff     <= csr_data[6:0];
               CSR_DEVICE_TYPE: device_type_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept) begin
            node_ff <= node_in;
         end
      end
   end

   assign rsp_tx_valid         = rsp_data.tx_valid;
   assign rsp_tx_id            = rsp_data.tx_id;
   assign rsp_tx_length        = rsp_data.tx_length;
   assign rsp_tx_data          = rsp_data.tx_data;
   assign rsp_node_state       = rsp_data.node_state;
   assign rsp_speed_mode       = rsp_data.speed_mode;
   assign rsp_target_velocity  = $signed(rsp_data.target_velocity);
   assign rsp_amplitude_level  = rsp_data.amplitude_level;
   assign rsp_heartbeat_period = rsp_data.heartbeat_period;

endmodule
